// File: src/world_to_screen_projection_core_assert.svh
// Assertion macros used by the checker file of the projection core.
`ifndef WORLD_TO_SCREEN_PROJECTION_CORE_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WTSP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WTSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/wtsp_pkg.sv
// Types, constants, microcode table and helpers of the world-to-screen projection core.
package wtsp_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = 4;
    localparam int MAT_DEPTH     = 16;
    localparam int MAT_ROWS      = 4;
    localparam int WIN_W         = 14;
    localparam int HALF_W        = WIN_W - 1;
    localparam int CFG_IDX_W     = 1;
    localparam int PROD_W        = 2 * DATA_W;
    // Translation plus three floored products, with headroom.
    localparam int ACC_W         = PROD_W - FRAC_BITS + 2;
    localparam int W10_W         = ACC_W + 4;
    localparam int NX_LIMIT_BITS = 40;
    localparam int QB            = NX_LIMIT_BITS + 2;
    localparam int DR_W          = ACC_W + 1;
    localparam int CNT_W         = $clog2(QB);
    localparam int NX_W          = QB;
    localparam int VPROD_W       = HALF_W + 1 + NX_W;
    localparam int VSUM_W        = VPROD_W + 2;
    localparam int PC_W          = 5;

    localparam logic [WIN_W-1:0] WIDTH_RESET  = WIN_W'(1024);
    localparam logic [WIN_W-1:0] HEIGHT_RESET = WIN_W'(768);

    localparam logic [QB-1:0] NX_LIMIT = {2'b01, {NX_LIMIT_BITS{1'b0}}};
    localparam logic signed [W10_W-1:0] VIS_THRESH =
        {{(W10_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [VSUM_W-1:0] SAT_HI =
        {{(VSUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [VSUM_W-1:0] SAT_LO =
        {{(VSUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_W = 3;
    localparam int COL_T = 3;

    localparam logic [PC_W-1:0] STEP_HIDDEN = PC_W'(27);

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_PROJECT = 1'b1
    } op_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef enum logic [2:0] {
        SQ_NEXT,
        SQ_BRANCH_HIDDEN,
        SQ_WAIT_DIV,
        SQ_EMIT_SHOWN,
        SQ_EMIT_HIDDEN
    } seq_op_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_PX,
        MUL_PY,
        MUL_PZ
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_X,
        ST_Y,
        ST_W
    } store_t;

    typedef enum logic [1:0] {
        DV_NONE,
        DV_X,
        DV_Y
    } div_op_t;

    typedef enum logic [1:0] {
        VP_NONE,
        VP_MUL_X,
        VP_MUL_Y
    } vp_op_t;

    typedef struct packed {
        seq_op_t          seq;
        logic [PC_W-1:0]  target;
        logic [IDX_W-1:0] rd_addr;
        mul_sel_t         mul;
        acc_op_t          acc;
        store_t           st;
        div_op_t          div;
        vp_op_t           vp;
    } ucode_t;

    // Column-major position of a matrix entry.
    function automatic logic [IDX_W-1:0] mat_addr(input int col, input int row);
        return IDX_W'(col * MAT_ROWS + row);
    endfunction

    function automatic ucode_t uc(input seq_op_t seq, input logic [IDX_W-1:0] rd,
                                  input mul_sel_t mul, input acc_op_t acc,
                                  input store_t st, input div_op_t div,
                                  input vp_op_t vp);
        ucode_t w;
        w.seq     = seq;
        w.target  = STEP_HIDDEN;
        w.rd_addr = rd;
        w.mul     = mul;
        w.acc     = acc;
        w.st      = st;
        w.div     = div;
        w.vp      = vp;
        return w;
    endfunction

    // Each row takes six steps: read translation, load it, then three reads
    // feeding the multiplier, each product being added in the step after its multiply.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            5'd0:  w = uc(SQ_NEXT, mat_addr(COL_T, ROW_X), MUL_NONE, ACC_NONE, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd1:  w = uc(SQ_NEXT, mat_addr(0, ROW_X), MUL_NONE, ACC_LOAD, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd2:  w = uc(SQ_NEXT, mat_addr(1, ROW_X), MUL_PX, ACC_NONE, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd3:  w = uc(SQ_NEXT, mat_addr(2, ROW_X), MUL_PY, ACC_ADD, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd4:  w = uc(SQ_NEXT, mat_addr(0, 0), MUL_PZ, ACC_ADD, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd5:  w = uc(SQ_NEXT, mat_addr(0, 0), MUL_NONE, ACC_ADD, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd6:  w = uc(SQ_NEXT, mat_addr(COL_T, ROW_Y), MUL_NONE, ACC_NONE, ST_X,
                          DV_NONE, VP_NONE);
            5'd7:  w = uc(SQ_NEXT, mat_addr(0, ROW_Y), MUL_NONE, ACC_LOAD, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd8:  w = uc(SQ_NEXT, mat_addr(1, ROW_Y), MUL_PX, ACC_NONE, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd9:  w = uc(SQ_NEXT, mat_addr(2, ROW_Y), MUL_PY, ACC_ADD, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd10: w = uc(SQ_NEXT, mat_addr(0, 0), MUL_PZ, ACC_ADD, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd11: w = uc(SQ_NEXT, mat_addr(0, 0), MUL_NONE, ACC_ADD, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd12: w = uc(SQ_NEXT, mat_addr(COL_T, ROW_W), MUL_NONE, ACC_NONE, ST_Y,
                          DV_NONE, VP_NONE);
            5'd13: w = uc(SQ_NEXT, mat_addr(0, ROW_W), MUL_NONE, ACC_LOAD, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd14: w = uc(SQ_NEXT, mat_addr(1, ROW_W), MUL_PX, ACC_NONE, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd15: w = uc(SQ_NEXT, mat_addr(2, ROW_W), MUL_PY, ACC_ADD, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd16: w = uc(SQ_NEXT, mat_addr(0, 0), MUL_PZ, ACC_ADD, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd17: w = uc(SQ_NEXT, mat_addr(0, 0), MUL_NONE, ACC_ADD, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd18: w = uc(SQ_NEXT, mat_addr(0, 0), MUL_NONE, ACC_NONE, ST_W,
                          DV_NONE, VP_NONE);
            5'd19: w = uc(SQ_BRANCH_HIDDEN, mat_addr(0, 0), MUL_NONE, ACC_NONE, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd20: w = uc(SQ_NEXT, mat_addr(0, 0), MUL_NONE, ACC_NONE, ST_NONE,
                          DV_X, VP_NONE);
            5'd21: w = uc(SQ_WAIT_DIV, mat_addr(0, 0), MUL_NONE, ACC_NONE, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd22: w = uc(SQ_NEXT, mat_addr(0, 0), MUL_NONE, ACC_NONE, ST_NONE,
                          DV_Y, VP_NONE);
            5'd23: w = uc(SQ_WAIT_DIV, mat_addr(0, 0), MUL_NONE, ACC_NONE, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd24: w = uc(SQ_NEXT, mat_addr(0, 0), MUL_NONE, ACC_NONE, ST_NONE,
                          DV_NONE, VP_MUL_X);
            5'd25: w = uc(SQ_NEXT, mat_addr(0, 0), MUL_NONE, ACC_NONE, ST_NONE,
                          DV_NONE, VP_MUL_Y);
            5'd26: w = uc(SQ_EMIT_SHOWN, mat_addr(0, 0), MUL_NONE, ACC_NONE, ST_NONE,
                          DV_NONE, VP_NONE);
            5'd27: w = uc(SQ_EMIT_HIDDEN, mat_addr(0, 0), MUL_NONE, ACC_NONE, ST_NONE,
                          DV_NONE, VP_NONE);
            default: w = uc(SQ_EMIT_HIDDEN, mat_addr(0, 0), MUL_NONE, ACC_NONE, ST_NONE,
                            DV_NONE, VP_NONE);
        endcase
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_data(
        input logic signed [VSUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[DATA_W-1:0];
        end
        else if (v < SAT_LO) begin
            r = SAT_LO[DATA_W-1:0];
        end
        else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/wtsp_if.sv
// Request and result channel interfaces of the projection core.
interface wtsp_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   op;
    logic [wtsp_pkg::IDX_W-1:0]             entry_index;
    logic signed [wtsp_pkg::DATA_W-1:0]     entry_value;
    logic signed [wtsp_pkg::DATA_W-1:0]     pos_x;
    logic signed [wtsp_pkg::DATA_W-1:0]     pos_y;
    logic signed [wtsp_pkg::DATA_W-1:0]     pos_z;

    modport source (output valid, op, entry_index, entry_value, pos_x, pos_y, pos_z,
                    input ready);
    modport sink (input valid, op, entry_index, entry_value, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface wtsp_res_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   visible;
    logic signed [wtsp_pkg::DATA_W-1:0]     screen_x;
    logic signed [wtsp_pkg::DATA_W-1:0]     screen_y;

    modport source (output valid, visible, screen_x, screen_y, input ready);
    modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface

// File: src/world_to_screen_projection_core.sv
// Top level of the world-to-screen projection core: microcode sequencer and datapath.
// A load request is written while idle and leaves the core ready; a point holds off
// requests until its result is registered. A visible point runs the matrix MAC steps on
// one 32x32 multiplier, then two restoring divisions (one bit a cycle), then the
// viewport steps. A point behind the near limit is hidden and branches straight to its
// result; a division whose quotient is sure to exceed the clamp is skipped.
// Reset clears the sequencer and result valid and sets a 1024x768 viewport.
module world_to_screen_projection_core (
    input  logic                            clk,
    input  logic                            rst_n,
    wtsp_cmd_if.sink                        cmd,
    wtsp_res_if.source                      result,
    input  logic                            cfg_we,
    input  logic [wtsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wtsp_pkg::WIN_W-1:0]      cfg_wdata
);

    wtsp_pkg::seq_state_t                   state_reg, state_next;
    logic [wtsp_pkg::PC_W-1:0]              pc_reg, pc_next;
    wtsp_pkg::ucode_t                       uw;
    logic                                   run;
    logic                                   cmd_fire;
    logic                                   emit_ok;
    logic                                   emit_shown;
    logic                                   emit_hidden;

    logic [wtsp_pkg::WIN_W-1:0]             win_w_reg, win_h_reg;
    logic [wtsp_pkg::HALF_W-1:0]            half_w, half_h;

    logic [wtsp_pkg::DATA_W-1:0]            mat_mem [wtsp_pkg::MAT_DEPTH];
    logic signed [wtsp_pkg::DATA_W-1:0]     mat_rd_reg;
    logic signed [wtsp_pkg::DATA_W-1:0]     px_reg, py_reg, pz_reg, mul_opnd;
    logic signed [wtsp_pkg::PROD_W-1:0]     prod_reg;
    logic signed [wtsp_pkg::ACC_W-1:0]      prod_floor;
    logic signed [wtsp_pkg::ACC_W-1:0]      acc_reg, x_reg, y_reg, w_reg;
    logic signed [wtsp_pkg::W10_W-1:0]      w_times10;
    logic                                   visible_w;

    logic                                   div_start;
    logic                                   div_busy_reg, div_fin_reg;
    logic [wtsp_pkg::CNT_W-1:0]             div_cnt_reg;
    logic                                   div_neg_reg;
    wtsp_pkg::div_op_t                      div_dst_reg;
    logic [wtsp_pkg::DR_W-1:0]              div_rem_reg;
    logic [wtsp_pkg::QB-1:0]                div_sh_reg, div_quo_reg;
    logic [wtsp_pkg::ACC_W-1:0]             div_den_reg;
    logic signed [wtsp_pkg::ACC_W-1:0]      div_num;
    logic                                   div_neg;
    logic [wtsp_pkg::ACC_W-1:0]             div_mag, div_head;
    logic                                   div_ovf;
    logic [wtsp_pkg::DR_W-1:0]              div_trial, div_diff;
    logic                                   div_ge;
    logic [wtsp_pkg::QB-1:0]                div_clamped;
    logic signed [wtsp_pkg::NX_W-1:0]       div_result, div_ovf_val;
    logic                                   div_wr_en;
    wtsp_pkg::div_op_t                      div_wr_dst;
    logic signed [wtsp_pkg::NX_W-1:0]       div_wr_val;
    logic signed [wtsp_pkg::NX_W-1:0]       nx_reg, ny_reg;

    logic [wtsp_pkg::HALF_W-1:0]            vmul_half;
    logic signed [wtsp_pkg::NX_W-1:0]       vmul_norm;
    logic signed [wtsp_pkg::VPROD_W-1:0]    vmul_res, vprod_reg;
    logic signed [wtsp_pkg::VSUM_W-1:0]     half_w_fx, half_h_fx, vp_sum_x, vp_sum_y;
    logic signed [wtsp_pkg::DATA_W-1:0]     sx_reg;

    logic                                   res_valid_reg;
    logic                                   res_visible_reg;
    logic signed [wtsp_pkg::DATA_W-1:0]     res_sx_reg, res_sy_reg;

    // ---------------- sequencer ----------------

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            wtsp_pkg::SEQ_IDLE:
            begin
                if (cmd_fire && (wtsp_pkg::op_t'(cmd.op) == wtsp_pkg::OP_PROJECT))
                begin
                    state_next = wtsp_pkg::SEQ_RUN;
                    pc_next    = '0;
                end
            end
            wtsp_pkg::SEQ_RUN:
            begin
                unique case (uw.seq)
                    wtsp_pkg::SQ_NEXT:
                    begin
                        pc_next = pc_reg + wtsp_pkg::PC_W'(1);
                    end
                    wtsp_pkg::SQ_BRANCH_HIDDEN:
                    begin
                        pc_next = visible_w ? pc_reg + wtsp_pkg::PC_W'(1) : uw.target;
                    end
                    wtsp_pkg::SQ_WAIT_DIV:
                    begin
                        if (!div_busy_reg)
                        begin
                            pc_next = pc_reg + wtsp_pkg::PC_W'(1);
                        end
                    end
                    wtsp_pkg::SQ_EMIT_SHOWN,
                    wtsp_pkg::SQ_EMIT_HIDDEN:
                    begin
                        if (emit_ok)
                        begin
                            state_next = wtsp_pkg::SEQ_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = wtsp_pkg::SEQ_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = wtsp_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        uw          = wtsp_pkg::ucode_rom(pc_reg);
        run         = (state_reg == wtsp_pkg::SEQ_RUN);
        cmd.ready   = (state_reg == wtsp_pkg::SEQ_IDLE);
        cmd_fire    = cmd.valid && cmd.ready;
        emit_ok     = !res_valid_reg || result.ready;
        emit_shown  = run && (uw.seq == wtsp_pkg::SQ_EMIT_SHOWN) && emit_ok;
        emit_hidden = run && (uw.seq == wtsp_pkg::SQ_EMIT_HIDDEN) && emit_ok;
        div_start   = run && (uw.div != wtsp_pkg::DV_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wtsp_pkg::SEQ_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    // ---------------- configuration ----------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w_reg <= wtsp_pkg::WIDTH_RESET;
            win_h_reg <= wtsp_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wtsp_pkg::CFG_WIDTH:  win_w_reg <= cfg_wdata;
                wtsp_pkg::CFG_HEIGHT: win_h_reg <= cfg_wdata;
            endcase
        end
    end

    assign half_w = win_w_reg[wtsp_pkg::WIN_W-1:1];
    assign half_h = win_h_reg[wtsp_pkg::WIN_W-1:1];

    // ---------------- matrix store ----------------

    always_ff @(posedge clk)
    begin
        if (cmd_fire && (wtsp_pkg::op_t'(cmd.op) == wtsp_pkg::OP_LOAD))
        begin
            mat_mem[cmd.entry_index] <= cmd.entry_value;
        end
        mat_rd_reg <= $signed(mat_mem[uw.rd_addr]);
    end

    // ---------------- multiply-accumulate ----------------

    always_comb
    begin
        unique case (uw.mul)
            wtsp_pkg::MUL_PX:   mul_opnd = px_reg;
            wtsp_pkg::MUL_PY:   mul_opnd = py_reg;
            wtsp_pkg::MUL_PZ:   mul_opnd = pz_reg;
            wtsp_pkg::MUL_NONE: mul_opnd = px_reg;
        endcase
    end

    // Arithmetic shift floors the product toward minus infinity.
    assign prod_floor =
        wtsp_pkg::ACC_W'($signed(prod_reg[wtsp_pkg::PROD_W-1:wtsp_pkg::FRAC_BITS]));

    assign w_times10 = (wtsp_pkg::W10_W'(w_reg) <<< 3) + (wtsp_pkg::W10_W'(w_reg) <<< 1);
    assign visible_w = (w_times10 >= wtsp_pkg::VIS_THRESH);

    always_ff @(posedge clk)
    begin
        if (cmd_fire && (wtsp_pkg::op_t'(cmd.op) == wtsp_pkg::OP_PROJECT))
        begin
            px_reg <= cmd.pos_x;
            py_reg <= cmd.pos_y;
            pz_reg <= cmd.pos_z;
        end
        if (run)
        begin
            if (uw.mul != wtsp_pkg::MUL_NONE)
            begin
                prod_reg <= mat_rd_reg * mul_opnd;
            end
            unique case (uw.acc)
                wtsp_pkg::ACC_LOAD: acc_reg <= wtsp_pkg::ACC_W'(mat_rd_reg);
                wtsp_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_floor;
                default:            acc_reg <= acc_reg;
            endcase
            unique case (uw.st)
                wtsp_pkg::ST_X:    x_reg <= acc_reg;
                wtsp_pkg::ST_Y:    y_reg <= acc_reg;
                wtsp_pkg::ST_W:    w_reg <= acc_reg;
                wtsp_pkg::ST_NONE: x_reg <= x_reg;
            endcase
        end
    end

    // ---------------- divider: |num| * 2^FRAC / w, one quotient bit a cycle ----------------

    assign div_num  = (uw.div == wtsp_pkg::DV_Y) ? y_reg : x_reg;
    assign div_neg  = div_num[wtsp_pkg::ACC_W-1];
    assign div_mag  = div_neg ? $unsigned(-div_num) : $unsigned(div_num);
    // If the leading part already reaches w, the quotient is beyond the clamp.
    assign div_head = div_mag >> (wtsp_pkg::QB - wtsp_pkg::FRAC_BITS);
    assign div_ovf  = (div_head >= $unsigned(w_reg));

    assign div_trial = {div_rem_reg[wtsp_pkg::DR_W-2:0], div_sh_reg[wtsp_pkg::QB-1]};
    assign div_ge    = (div_trial >= {1'b0, div_den_reg});
    assign div_diff  = div_trial - {1'b0, div_den_reg};

    assign div_clamped = (div_quo_reg > wtsp_pkg::NX_LIMIT) ? wtsp_pkg::NX_LIMIT : div_quo_reg;
    assign div_result  = div_neg_reg ? -$signed(div_clamped) : $signed(div_clamped);
    assign div_ovf_val = div_neg ? -$signed(wtsp_pkg::NX_LIMIT) : $signed(wtsp_pkg::NX_LIMIT);

    assign div_wr_en  = (div_start && div_ovf) || div_fin_reg;
    assign div_wr_dst = div_start ? uw.div : div_dst_reg;
    assign div_wr_val = div_start ? div_ovf_val : div_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_fin_reg  <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (div_start)
        begin
            div_busy_reg <= !div_ovf;
            div_fin_reg  <= 1'b0;
            div_cnt_reg  <= wtsp_pkg::CNT_W'(wtsp_pkg::QB - 1);
        end
        else if (div_fin_reg)
        begin
            div_busy_reg <= 1'b0;
            div_fin_reg  <= 1'b0;
        end
        else if (div_busy_reg)
        begin
            if (div_cnt_reg == '0)
            begin
                div_fin_reg <= 1'b1;
            end
            else
            begin
                div_cnt_reg <= div_cnt_reg - wtsp_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_rem_reg <= wtsp_pkg::DR_W'(div_head);
            div_sh_reg  <= {div_mag[wtsp_pkg::QB-wtsp_pkg::FRAC_BITS-1:0],
                            {wtsp_pkg::FRAC_BITS{1'b0}}};
            div_quo_reg <= '0;
            div_neg_reg <= div_neg;
            div_dst_reg <= uw.div;
            div_den_reg <= $unsigned(w_reg);
        end
        else if (div_busy_reg && !div_fin_reg)
        begin
            div_rem_reg <= div_ge ? div_diff : div_trial;
            div_sh_reg  <= div_sh_reg << 1;
            div_quo_reg <= {div_quo_reg[wtsp_pkg::QB-2:0], div_ge};
        end
        if (div_wr_en)
        begin
            if (div_wr_dst == wtsp_pkg::DV_Y)
            begin
                ny_reg <= div_wr_val;
            end
            else
            begin
                nx_reg <= div_wr_val;
            end
        end
    end

    // ---------------- viewport mapping ----------------

    assign vmul_half = (uw.vp == wtsp_pkg::VP_MUL_Y) ? half_h : half_w;
    assign vmul_norm = (uw.vp == wtsp_pkg::VP_MUL_Y) ? ny_reg : nx_reg;
    assign vmul_res  = $signed({1'b0, vmul_half}) * vmul_norm;

    assign half_w_fx = $signed({{(wtsp_pkg::VSUM_W - wtsp_pkg::HALF_W - wtsp_pkg::FRAC_BITS){1'b0}},
                                half_w, {wtsp_pkg::FRAC_BITS{1'b0}}});
    assign half_h_fx = $signed({{(wtsp_pkg::VSUM_W - wtsp_pkg::HALF_W - wtsp_pkg::FRAC_BITS){1'b0}},
                                half_h, {wtsp_pkg::FRAC_BITS{1'b0}}});
    assign vp_sum_x  = wtsp_pkg::VSUM_W'(vprod_reg) + half_w_fx;
    assign vp_sum_y  = half_h_fx - wtsp_pkg::VSUM_W'(vprod_reg);

    always_ff @(posedge clk)
    begin
        if (run && (uw.vp != wtsp_pkg::VP_NONE))
        begin
            vprod_reg <= vmul_res;
        end
        // The y product replaces the x product, so x is finished in the same step.
        if (run && (uw.vp == wtsp_pkg::VP_MUL_Y))
        begin
            sx_reg <= wtsp_pkg::sat_data(vp_sum_x);
        end
    end

    // ---------------- result register ----------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit_shown || emit_hidden)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_shown)
        begin
            res_visible_reg <= 1'b1;
            res_sx_reg      <= sx_reg;
            res_sy_reg      <= wtsp_pkg::sat_data(vp_sum_y);
        end
        else if (emit_hidden)
        begin
            res_visible_reg <= 1'b0;
            res_sx_reg      <= '0;
            res_sy_reg      <= '0;
        end
    end

    assign result.valid    = res_valid_reg;
    assign result.visible  = res_visible_reg;
    assign result.screen_x = res_sx_reg;
    assign result.screen_y = res_sy_reg;

endmodule

// File: src/wtsp_checker.sv
// Port-level checker of the projection core and its bind to the top level.
`include "world_to_screen_projection_core_assert.svh"

module wtsp_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cmd_valid,
    input logic                                 cmd_ready,
    input logic                                 cmd_op,
    input logic                                 res_valid,
    input logic                                 res_ready,
    input logic                                 res_visible,
    input logic signed [wtsp_pkg::DATA_W-1:0]   res_screen_x,
    input logic signed [wtsp_pkg::DATA_W-1:0]   res_screen_y
);

    `WTSP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_visible) && $stable(res_screen_x) && $stable(res_screen_y), "stalled result changed")

    `WTSP_ASSERT_SAME(a_hidden_zero, res_valid && !res_visible, (res_screen_x == 0) && (res_screen_y == 0), "hidden point with nonzero coordinates")

    `WTSP_ASSERT_NEXT(a_project_busy, cmd_valid && cmd_ready && (cmd_op == wtsp_pkg::OP_PROJECT), !cmd_ready, "core ready right after taking a point")

    `WTSP_ASSERT_NEXT(a_load_ready, cmd_valid && cmd_ready && (cmd_op == wtsp_pkg::OP_LOAD), cmd_ready, "core busy after a matrix load")

    `WTSP_ASSERT_SAME(a_result_from_run, $rose(res_valid), $past(!cmd_ready), "result appeared without a point in progress")

endmodule

bind world_to_screen_projection_core wtsp_checker u_wtsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .cmd_op       (cmd.op),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_visible  (result.visible),
    .res_screen_x (result.screen_x),
    .res_screen_y (result.screen_y)
);
